[rtl/core/rme_pkg.sv]
// Shared types, widths and constants for the rotation matrix to Euler angle unit.
// Holds the item structs, the CORDIC arctangent table and the fixed-point formats.
// No dependencies.
package rme_pkg;

   // Number of CORDIC rotations; the table stops at twenty-four entries.
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

   // Fixed-point constants.
   localparam int ONE_Q14 = 16384;
   localparam int ONE_Q28 = 1 << 28;
   localparam int DEG180  = 180 * 65536;

   // Output clamps in 1/128 degree.
   localparam int LIM_WIDE   = 23040;
   localparam int LIM_NARROW = 11520;

   // Internal widths.
   localparam int QW       = 18;  // unscaled quaternion components and t
   localparam int S1_N     = 19;  // root bits of sqrt(t * 2^20)
   localparam int S2_N     = 29;  // root bits of sqrt(2^56 - a^2)
   localparam int DIV_BITS = 15;  // quotient bits below the saturation point
   localparam int EW       = 32;  // Euler term width (Q28 products)
   localparam int CW       = 34;  // CORDIC x and y width
   localparam int ZW       = 26;  // CORDIC angle accumulator width

   typedef logic signed [15:0] comp_type;

   // One input item: the nine matrix elements.
   typedef struct packed {
      comp_type xaxis_0;
      comp_type xaxis_1;
      comp_type xaxis_2;
      comp_type yaxis_0;
      comp_type yaxis_1;
      comp_type yaxis_2;
      comp_type zaxis_0;
      comp_type zaxis_1;
      comp_type zaxis_2;
   } req_type;

   // One result item.
   typedef struct packed {
      comp_type                quat_0;
      comp_type                quat_1;
      comp_type                quat_2;
      comp_type                quat_3;
      logic signed [15:0]      angle_first;
      logic signed [14:0]      angle_second;
      logic signed [15:0]      angle_third;
      logic                    degenerate;
   } rsp_type;

   // Scaled quaternion and degenerate flag, carried down the pipeline.
   typedef struct packed {
      logic [3:0][15:0] quat;
      logic             degen;
   } carry_type;

   // Three atan2 argument pairs: lane 0 first angle, lane 1 asin, lane 2 third angle.
   typedef struct packed {
      logic [2:0][EW-1:0] ys;
      logic [2:0][EW-1:0] xs;
   } vec_type;

   // atan(2^-i) in units of 2^-16 degree.
   function automatic logic [ZW-1:0] atan_entry(input int idx);
      logic [ZW-1:0] v;
      case (idx)
         0:       v = ZW'(2949120);
         1:       v = ZW'(1740967);
         2:       v = ZW'(919879);
         3:       v = ZW'(466945);
         4:       v = ZW'(234379);
         5:       v = ZW'(117304);
         6:       v = ZW'(58666);
         7:       v = ZW'(29335);
         8:       v = ZW'(14668);
         9:       v = ZW'(7334);
         10:      v = ZW'(3667);
         11:      v = ZW'(1833);
         12:      v = ZW'(917);
         13:      v = ZW'(458);
         14:      v = ZW'(229);
         15:      v = ZW'(115);
         16:      v = ZW'(57);
         17:      v = ZW'(29);
         18:      v = ZW'(14);
         19:      v = ZW'(7);
         20:      v = ZW'(4);
         21:      v = ZW'(2);
         22:      v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/rme_quat_calc.sv]
// Quaternion front end: branch select, pipelined square root and scaling dividers.
// Produces the saturated Q1.14 quaternion and the degenerate flag.
// Depends on rme_pkg.
module rme_quat_calc (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rme_pkg::req_type   in_item,
   output logic               out_valid,
   output rme_pkg::carry_type out_carry
);
   import rme_pkg::*;

   localparam int RW        = S1_N + 2;
   localparam int SQ_SHIFT  = 20;
   localparam int NUM_SHIFT = 17;
   localparam int NW        = QW + NUM_SHIFT;
   localparam int DW        = S1_N + 1;

   typedef struct packed {
      logic [RW-1:0]       rem;
      logic [S1_N-1:0]     root;
      logic [2*S1_N-1:0]   rad;
      logic [3:0][QW-1:0]  q;
      logic                degen;
   } sq_type;

   typedef struct packed {
      logic [3:0][NW-1:0]       rem;
      logic [3:0][DIV_BITS-1:0] quo;
      logic [3:0]               neg;
      logic [3:0]               ovf;
      logic [DW-1:0]            dvs;
      logic                     degen;
   } dv_type;

   // Branch select on the diagonal and the unscaled components.
   logic signed [QW-1:0] x0, x1, x2, y0, y1, y2, z0, z1, z2;
   logic signed [QW-1:0] t_val;
   logic [3:0][QW-1:0]   q_val;
   sq_type               a_in;
   sq_type               a_ff;
   logic                 a_valid_ff;

   always_comb begin
      x0 = QW'(in_item.xaxis_0);
      x1 = QW'(in_item.xaxis_1);
      x2 = QW'(in_item.xaxis_2);
      y0 = QW'(in_item.yaxis_0);
      y1 = QW'(in_item.yaxis_1);
      y2 = QW'(in_item.yaxis_2);
      z0 = QW'(in_item.zaxis_0);
      z1 = QW'(in_item.zaxis_1);
      z2 = QW'(in_item.zaxis_2);
      if (z2 < 0) begin
         if (x0 > y1) begin
            t_val    = QW'(ONE_Q14) + x0 - y1 - z2;
            q_val[0] = t_val;
            q_val[1] = y0 + x1;
            q_val[2] = x2 + z0;
            q_val[3] = z1 - y2;
         end else begin
            t_val    = QW'(ONE_Q14) - x0 + y1 - z2;
            q_val[0] = y0 + x1;
            q_val[1] = t_val;
            q_val[2] = z1 + y2;
            q_val[3] = x2 - z0;
         end
      end else begin
         if (x0 < -y1) begin
            t_val    = QW'(ONE_Q14) - x0 - y1 + z2;
            q_val[0] = x2 + z0;
            q_val[1] = z1 + y2;
            q_val[2] = t_val;
            q_val[3] = y0 - x1;
         end else begin
            t_val    = QW'(ONE_Q14) + x0 + y1 + z2;
            q_val[0] = z1 - y2;
            q_val[1] = x2 - z0;
            q_val[2] = y0 - x1;
            q_val[3] = t_val;
         end
      end
      a_in.rem   = '0;
      a_in.root  = '0;
      a_in.rad   = (2 * S1_N)'(t_val[QW-2:0]) << SQ_SHIFT;
      a_in.q     = q_val;
      a_in.degen = (t_val <= 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
      if (adv) begin
         a_ff <= a_in;
      end
   end

   // Square root of t * 2^20, one root bit per stage.
   sq_type sq_ff       [S1_N];
   logic   sq_valid_ff [S1_N];

   for (genvar g = 0; g < S1_N; g++) begin : g_sqrt
      sq_type        cur;
      sq_type        nxt;
      logic          cur_valid;
      logic [RW-1:0] rem_n;
      logic [RW-1:0] trial;

      if (g == 0) begin : g_head
         assign cur       = a_ff;
         assign cur_valid = a_valid_ff;
      end else begin : g_body
         assign cur       = sq_ff[g-1];
         assign cur_valid = sq_valid_ff[g-1];
      end

      always_comb begin
         nxt     = cur;
         rem_n   = {cur.rem[RW-3:0], cur.rad[2*S1_N-1 -: 2]};
         trial   = {cur.root, 2'b01};
         nxt.rad = cur.rad << 2;
         if (rem_n >= trial) begin
            nxt.rem  = rem_n - trial;
            nxt.root = {cur.root[S1_N-2:0], 1'b1};
         end else begin
            nxt.rem  = rem_n;
            nxt.root = {cur.root[S1_N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[g] <= cur_valid;
         end
         if (adv) begin
            sq_ff[g] <= nxt;
         end
      end
   end

   // Divider setup: numerator |q| * 2^17 + s, divisor 2s, overflow check.
   sq_type          sq_last;
   dv_type          d0_in;
   dv_type          d0_ff;
   logic            d0_valid_ff;
   logic [QW-1:0]   mag;

   always_comb begin
      sq_last     = sq_ff[S1_N-1];
      d0_in.dvs   = {sq_last.root, 1'b0};
      d0_in.degen = sq_last.degen;
      d0_in.quo   = '0;
      mag         = '0;
      for (int k = 0; k < 4; k++) begin
         d0_in.neg[k] = sq_last.q[k][QW-1];
         mag          = sq_last.q[k][QW-1] ? (QW'(0) - sq_last.q[k]) : sq_last.q[k];
         d0_in.rem[k] = (NW'(mag) << NUM_SHIFT) + NW'(sq_last.root);
         d0_in.ovf[k] = (d0_in.rem[k] >= (NW'(d0_in.dvs) << DIV_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else if (adv) begin
         d0_valid_ff <= sq_valid_ff[S1_N-1];
      end
      if (adv) begin
         d0_ff <= d0_in;
      end
   end

   // Restoring division, one quotient bit per stage for all four components.
   dv_type dv_ff       [DIV_BITS];
   logic   dv_valid_ff [DIV_BITS];

   for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
      localparam int B = DIV_BITS - 1 - g;
      dv_type        cur;
      dv_type        nxt;
      logic          cur_valid;
      logic [NW-1:0] shifted;

      if (g == 0) begin : g_head
         assign cur       = d0_ff;
         assign cur_valid = d0_valid_ff;
      end else begin : g_body
         assign cur       = dv_ff[g-1];
         assign cur_valid = dv_valid_ff[g-1];
      end

      always_comb begin
         nxt     = cur;
         shifted = NW'(cur.dvs) << B;
         for (int k = 0; k < 4; k++) begin
            if (cur.rem[k] >= shifted) begin
               nxt.rem[k]    = cur.rem[k] - shifted;
               nxt.quo[k][B] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[g] <= cur_valid;
         end
         if (adv) begin
            dv_ff[g] <= nxt;
         end
      end
   end

   // Saturate to one and restore the sign.
   dv_type              dv_last;
   carry_type           f_in;
   carry_type           f_ff;
   logic                f_valid_ff;
   logic [DIV_BITS-1:0] r_sat;
   logic [15:0]         r_ext;

   always_comb begin
      dv_last    = dv_ff[DIV_BITS-1];
      f_in.degen = dv_last.degen;
      r_sat      = '0;
      r_ext      = '0;
      for (int k = 0; k < 4; k++) begin
         if (dv_last.ovf[k] || (dv_last.quo[k] > DIV_BITS'(ONE_Q14))) begin
            r_sat = DIV_BITS'(ONE_Q14);
         end else begin
            r_sat = dv_last.quo[k];
         end
         r_ext        = 16'(r_sat);
         f_in.quat[k] = dv_last.neg[k] ? (16'd0 - r_ext) : r_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= dv_valid_ff[DIV_BITS-1];
      end
      if (adv) begin
         f_ff <= f_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_carry = f_ff;

endmodule

[rtl/core/rme_angle_prep.sv]
// Euler argument preparation: quaternion products, sums, asin clamp, and the
// pipelined square root that gives the asin cosine term.
// Depends on rme_pkg.
module rme_angle_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rme_pkg::carry_type in_carry,
   output logic               out_valid,
   output rme_pkg::vec_type   out_vec,
   output rme_pkg::carry_type out_carry
);
   import rme_pkg::*;

   localparam int SQW       = 2 * S2_N;
   localparam int RW        = S2_N + 2;
   localparam int ONE_SHIFT = 2 * (S2_N - 1);

   typedef struct packed {
      logic [8:0][EW-1:0] p;
      carry_type          cr;
   } p1_type;

   typedef struct packed {
      logic [EW-1:0] a0;
      logic [EW-1:0] a1;
      logic [EW-1:0] b0;
      logic [EW-1:0] b1;
      logic [EW-1:0] t2;
      carry_type     cr;
   } p2_type;

   typedef struct packed {
      logic [EW-1:0] a0;
      logic [EW-1:0] a1;
      logic [EW-1:0] b0;
      logic [EW-1:0] b1;
      logic [EW-1:0] t2;
      logic [SQW-1:0] sq;
      carry_type     cr;
   } p3_type;

   typedef struct packed {
      logic [RW-1:0]   rem;
      logic [S2_N-1:0] root;
      logic [SQW-1:0]  rad;
      logic [EW-1:0]   a0;
      logic [EW-1:0]   a1;
      logic [EW-1:0]   b0;
      logic [EW-1:0]   b1;
      logic [EW-1:0]   t2;
      carry_type       cr;
   } sq_type;

   // Nine component products.
   logic signed [EW-1:0] q0, q1, q2, q3;
   p1_type               p1_in;
   p1_type               p1_ff;
   logic                 p1_valid_ff;

   always_comb begin
      q0 = EW'($signed(in_carry.quat[0]));
      q1 = EW'($signed(in_carry.quat[1]));
      q2 = EW'($signed(in_carry.quat[2]));
      q3 = EW'($signed(in_carry.quat[3]));
      p1_in.p[0] = q0 * q1;
      p1_in.p[1] = q2 * q3;
      p1_in.p[2] = q1 * q1;
      p1_in.p[3] = q2 * q2;
      p1_in.p[4] = q0 * q3;
      p1_in.p[5] = q1 * q2;
      p1_in.p[6] = q3 * q3;
      p1_in.p[7] = q0 * q2;
      p1_in.p[8] = q3 * q1;
      p1_in.cr   = in_carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= in_valid;
      end
      if (adv) begin
         p1_ff <= p1_in;
      end
   end

   // Sums of products and the clamped asin argument.
   logic signed [EW-1:0] sp [9];
   logic signed [EW-1:0] t2_raw;
   p2_type               p2_in;
   p2_type               p2_ff;
   logic                 p2_valid_ff;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         sp[k] = $signed(p1_ff.p[k]);
      end
      p2_in.a0 = 2 * (sp[0] + sp[1]);
      p2_in.a1 = ONE_Q28 - 2 * (sp[2] + sp[3]);
      p2_in.b0 = 2 * (sp[4] + sp[5]);
      p2_in.b1 = ONE_Q28 - 2 * (sp[3] + sp[6]);
      t2_raw   = 2 * (sp[7] - sp[8]);
      if (t2_raw > ONE_Q28) begin
         p2_in.t2 = EW'(ONE_Q28);
      end else if (t2_raw < -ONE_Q28) begin
         p2_in.t2 = EW'(-ONE_Q28);
      end else begin
         p2_in.t2 = t2_raw;
      end
      p2_in.cr = p1_ff.cr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (adv) begin
         p2_ff <= p2_in;
      end
   end

   // Square of the asin argument.
   logic [S2_N-1:0] t2_mag;
   logic [EW-1:0]   t2_abs;
   p3_type          p3_in;
   p3_type          p3_ff;
   logic            p3_valid_ff;

   always_comb begin
      t2_abs   = p2_ff.t2[EW-1] ? (EW'(0) - p2_ff.t2) : p2_ff.t2;
      t2_mag   = t2_abs[S2_N-1:0];
      p3_in.a0 = p2_ff.a0;
      p3_in.a1 = p2_ff.a1;
      p3_in.b0 = p2_ff.b0;
      p3_in.b1 = p2_ff.b1;
      p3_in.t2 = p2_ff.t2;
      p3_in.sq = SQW'(t2_mag) * SQW'(t2_mag);
      p3_in.cr = p2_ff.cr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (adv) begin
         p3_ff <= p3_in;
      end
   end

   // Root seed: radicand is 2^56 minus the square.
   sq_type s_head;

   always_comb begin
      s_head.rem  = '0;
      s_head.root = '0;
      s_head.rad  = (SQW'(1) << ONE_SHIFT) - p3_ff.sq;
      s_head.a0   = p3_ff.a0;
      s_head.a1   = p3_ff.a1;
      s_head.b0   = p3_ff.b0;
      s_head.b1   = p3_ff.b1;
      s_head.t2   = p3_ff.t2;
      s_head.cr   = p3_ff.cr;
   end

   // Square root, one root bit per stage.
   sq_type sq_ff       [S2_N];
   logic   sq_valid_ff [S2_N];

   for (genvar g = 0; g < S2_N; g++) begin : g_sqrt
      sq_type        cur;
      sq_type        nxt;
      logic          cur_valid;
      logic [RW-1:0] rem_n;
      logic [RW-1:0] trial;

      if (g == 0) begin : g_head
         assign cur       = s_head;
         assign cur_valid = p3_valid_ff;
      end else begin : g_body
         assign cur       = sq_ff[g-1];
         assign cur_valid = sq_valid_ff[g-1];
      end

      always_comb begin
         nxt     = cur;
         rem_n   = {cur.rem[RW-3:0], cur.rad[SQW-1 -: 2]};
         trial   = {cur.root, 2'b01};
         nxt.rad = cur.rad << 2;
         if (rem_n >= trial) begin
            nxt.rem  = rem_n - trial;
            nxt.root = {cur.root[S2_N-2:0], 1'b1};
         end else begin
            nxt.rem  = rem_n;
            nxt.root = {cur.root[S2_N-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[g] <= cur_valid;
         end
         if (adv) begin
            sq_ff[g] <= nxt;
         end
      end
   end

   // Lane order: first angle, asin, third angle.
   sq_type sq_last;

   always_comb begin
      sq_last       = sq_ff[S2_N-1];
      out_vec.ys[0] = sq_last.a0;
      out_vec.xs[0] = sq_last.a1;
      out_vec.ys[1] = sq_last.t2;
      out_vec.xs[1] = EW'(sq_last.root);
      out_vec.ys[2] = sq_last.b0;
      out_vec.xs[2] = sq_last.b1;
      out_carry     = sq_last.cr;
   end

   assign out_valid = sq_valid_ff[S2_N-1];

endmodule

[rtl/core/rme_cordic.sv]
// Three-lane pipelined vectoring CORDIC giving atan2 in 1/128 degree.
// One rotation per stage per lane, then rounding and clamping.
// Depends on rme_pkg.
module rme_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rme_pkg::vec_type   in_vec,
   input  rme_pkg::carry_type in_carry,
   output logic               out_valid,
   output logic [2:0][15:0]   out_ang,
   output rme_pkg::carry_type out_carry
);
   import rme_pkg::*;

   localparam int RND_SHIFT = 9;

   typedef struct packed {
      logic [2:0][CW-1:0] x;
      logic [2:0][CW-1:0] y;
      logic [2:0][ZW-1:0] z;
      logic [2:0]         zero;
      carry_type          cr;
   } cd_type;

   // Fold the left half plane onto the right one.
   logic signed [CW-1:0] xv;
   logic signed [CW-1:0] yv;
   cd_type               pre_in;
   cd_type               pre_ff;
   logic                 pre_valid_ff;

   always_comb begin
      xv        = '0;
      yv        = '0;
      pre_in.cr = in_carry;
      for (int l = 0; l < 3; l++) begin
         xv = CW'($signed(in_vec.xs[l]));
         yv = CW'($signed(in_vec.ys[l]));
         pre_in.zero[l] = (xv == 0) && (yv == 0);
         if (xv < 0) begin
            pre_in.z[l] = (yv >= 0) ? ZW'(DEG180) : ZW'(-DEG180);
            pre_in.x[l] = -xv;
            pre_in.y[l] = -yv;
         end else begin
            pre_in.z[l] = '0;
            pre_in.x[l] = xv;
            pre_in.y[l] = yv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_valid_ff <= in_valid;
      end
      if (adv) begin
         pre_ff <= pre_in;
      end
   end

   // Rotation stages.
   cd_type cd_ff       [CORDIC_RUN];
   logic   cd_valid_ff [CORDIC_RUN];

   for (genvar g = 0; g < CORDIC_RUN; g++) begin : g_rot
      localparam logic [ZW-1:0] ATAN_I = atan_entry(g);
      cd_type               cur;
      cd_type               nxt;
      logic                 cur_valid;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;

      if (g == 0) begin : g_head
         assign cur       = pre_ff;
         assign cur_valid = pre_valid_ff;
      end else begin : g_body
         assign cur       = cd_ff[g-1];
         assign cur_valid = cd_valid_ff[g-1];
      end

      always_comb begin
         nxt = cur;
         xs  = '0;
         ys  = '0;
         for (int l = 0; l < 3; l++) begin
            xs = $signed(cur.x[l]);
            ys = $signed(cur.y[l]);
            if (ys >= 0) begin
               nxt.x[l] = xs + (ys >>> g);
               nxt.y[l] = ys - (xs >>> g);
               nxt.z[l] = cur.z[l] + ATAN_I;
            end else begin
               nxt.x[l] = xs - (ys >>> g);
               nxt.y[l] = ys + (xs >>> g);
               nxt.z[l] = cur.z[l] - ATAN_I;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cd_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            cd_valid_ff[g] <= cur_valid;
         end
         if (adv) begin
            cd_ff[g] <= nxt;
         end
      end
   end

   // Round to 1/128 degree and clamp each lane to its range.
   cd_type               cd_last;
   logic signed [ZW:0]   z_rnd;
   logic signed [ZW:0]   z_sh;
   logic [2:0][15:0]     ang_in;
   logic [2:0][15:0]     ang_ff;
   carry_type            cr_ff;
   logic                 fin_valid_ff;
   int                   lim;

   always_comb begin
      cd_last = cd_ff[CORDIC_RUN-1];
      z_rnd   = '0;
      z_sh    = '0;
      lim     = LIM_WIDE;
      for (int l = 0; l < 3; l++) begin
         lim   = (l == 1) ? LIM_NARROW : LIM_WIDE;
         z_rnd = (ZW + 1)'($signed(cd_last.z[l])) + (ZW + 1)'(256);
         z_sh  = z_rnd >>> RND_SHIFT;
         if (cd_last.zero[l]) begin
            ang_in[l] = '0;
         end else if (z_sh > lim) begin
            ang_in[l] = 16'(lim);
         end else if (z_sh < -lim) begin
            ang_in[l] = 16'(-lim);
         end else begin
            ang_in[l] = z_sh[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= cd_valid_ff[CORDIC_RUN-1];
      end
      if (adv) begin
         ang_ff <= ang_in;
         cr_ff  <= cd_last.cr;
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_ang   = ang_ff;
   assign out_carry = cr_ff;

endmodule

[rtl/core/rotation_matrix_to_euler_unit.sv]
// Rotation matrix to quaternion and Euler angles, fully pipelined.
// Registered in order: the quaternion root and dividers, the asin root, the atan2
// CORDIC stages, then one output register.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset is synchronous and clears every valid bit; payload registers are not reset.
// Depends on rme_pkg, rme_quat_calc, rme_angle_prep and rme_cordic.
module rotation_matrix_to_euler_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rme_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rme_pkg::rsp_type rsp_item
);
   import rme_pkg::*;

   // The pipeline moves whenever the output register can take or drop an item.
   logic      adv;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   logic      qc_valid;
   carry_type qc_carry;
   logic      ap_valid;
   vec_type   ap_vec;
   carry_type ap_carry;
   logic      cd_valid;
   logic [2:0][15:0] cd_ang;
   carry_type cd_carry;

   rme_quat_calc u_quat (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .out_valid (qc_valid),
      .out_carry (qc_carry)
   );

   rme_angle_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (qc_valid),
      .in_carry  (qc_carry),
      .out_valid (ap_valid),
      .out_vec   (ap_vec),
      .out_carry (ap_carry)
   );

   rme_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ap_valid),
      .in_vec    (ap_vec),
      .in_carry  (ap_carry),
      .out_valid (cd_valid),
      .out_ang   (cd_ang),
      .out_carry (cd_carry)
   );

   // Assemble the result item; a degenerate matrix reports zeros.
   rsp_type rsp_in;

   always_comb begin
      if (cd_carry.degen) begin
         rsp_in            = '0;
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.quat_0       = cd_carry.quat[0];
         rsp_in.quat_1       = cd_carry.quat[1];
         rsp_in.quat_2       = cd_carry.quat[2];
         rsp_in.quat_3       = cd_carry.quat[3];
         rsp_in.angle_first  = cd_ang[0];
         rsp_in.angle_second = cd_ang[1][14:0];
         rsp_in.angle_third  = cd_ang[2];
         rsp_in.degenerate   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cd_valid;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

   // Every branch gives a positive t for 16-bit elements.
   a_never_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_ff.degenerate)
      else $error("degenerate result for a 16-bit matrix");

   // Quaternion components 0 and 3 stay within plus or minus one.
   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_ff.quat_0) <= 16384 && $signed(rsp_ff.quat_0) >= -16384 &&
                        $signed(rsp_ff.quat_3) <= 16384 && $signed(rsp_ff.quat_3) >= -16384))
      else $error("quaternion component out of range");

   // The first and second angles stay within their clamps.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_ff.angle_second) <= 11520 &&
                        $signed(rsp_ff.angle_second) >= -11520 &&
                        $signed(rsp_ff.angle_first) <= 23040 &&
                        $signed(rsp_ff.angle_first) >= -23040))
      else $error("angle out of range");

endmodule

[verif/tb_rotation_matrix_to_euler_unit.sv]
// Self-checking testbench for rotation_matrix_to_euler_unit.
// Predicts quaternion and Euler angles per matrix item and compares each result in order.
// Depends on rme_pkg and the unit under test.
module tb_rotation_matrix_to_euler_unit;
   import rme_pkg::*;

   localparam int LATENCY      = 72 + CORDIC_STAGES;
   localparam longint MAX_CYCLES = 2000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   rsp_type pending_angles[$];
   int      error_count;
   int      result_count;
   int      degenerate_count;
   longint  cycle_count = 0;
   bit      rsp_idle_enable;

   rotation_matrix_to_euler_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Floor shift right of a signed value.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Integer square root, floor.
   function automatic longint int_root(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Vectoring-mode CORDIC arctangent in 1/128 degree.
   function automatic longint cordic_atan2(longint y, longint x, longint lim);
      longint z, xn;
      longint table_val [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
         58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
         4, 2, 1, 0};
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         if (y >= 0) begin
            xn = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += table_val[i];
         end else begin
            xn = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= table_val[i];
         end
         x = xn;
      end
      return clamp_sym(floor_shift(z + 256, 9), lim);
   endfunction

   // Scale one component by 0.5/sqrt(t), rounding half away from zero.
   function automatic longint scale_component(longint q, longint s);
      longint unsigned mag, r;
      longint v;
      mag = (q < 0) ? -q : q;
      r = ((mag << 17) + s) / (2 * s);
      v = (r > ONE_Q14) ? ONE_Q14 : longint'(r);
      return (q < 0) ? -v : v;
   endfunction

   // Expected quaternion and angles for one matrix.
   function automatic rsp_type predict_angles(req_type m);
      longint x0, x1, x2, y0, y1, y2, z0, z1, z2, t, s, a0, a1, b0, b1, sn, cs;
      longint q [4];
      rsp_type r;
      x0 = m.xaxis_0; x1 = m.xaxis_1; x2 = m.xaxis_2;
      y0 = m.yaxis_0; y1 = m.yaxis_1; y2 = m.yaxis_2;
      z0 = m.zaxis_0; z1 = m.zaxis_1; z2 = m.zaxis_2;
      r = '0;
      if (z2 < 0) begin
         if (x0 > y1) begin
            t = ONE_Q14 + x0 - y1 - z2;
            q = '{t, y0 + x1, x2 + z0, z1 - y2};
         end else begin
            t = ONE_Q14 - x0 + y1 - z2;
            q = '{y0 + x1, t, z1 + y2, x2 - z0};
         end
      end else begin
         if (x0 < -y1) begin
            t = ONE_Q14 - x0 - y1 + z2;
            q = '{x2 + z0, z1 + y2, t, y0 - x1};
         end else begin
            t = ONE_Q14 + x0 + y1 + z2;
            q = '{z1 - y2, x2 - z0, y0 - x1, t};
         end
      end
      if (t <= 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      s = int_root(longint'(t) << 20);
      for (int k = 0; k < 4; k++) q[k] = scale_component(q[k], s);
      a0 = 2 * (q[0] * q[1] + q[2] * q[3]);
      a1 = (64'sd1 << 28) - 2 * (q[1] * q[1] + q[2] * q[2]);
      b0 = 2 * (q[0] * q[3] + q[1] * q[2]);
      b1 = (64'sd1 << 28) - 2 * (q[2] * q[2] + q[3] * q[3]);
      sn = clamp_sym(2 * (q[0] * q[2] - q[3] * q[1]), 64'sd1 << 28);
      cs = int_root((64'd1 << 56) - longint'(sn * sn));
      r.quat_0 = 16'(q[0]);
      r.quat_1 = 16'(q[1]);
      r.quat_2 = 16'(q[2]);
      r.quat_3 = 16'(q[3]);
      r.angle_first  = 16'(cordic_atan2(a0, a1, LIM_WIDE));
      r.angle_second = 15'(cordic_atan2(sn, cs, LIM_NARROW));
      r.angle_third  = 16'(cordic_atan2(b0, b1, LIM_WIDE));
      return r;
   endfunction

   // Append one expected result to the tail of the queue.
   function automatic void enqueue_expected(rsp_type r);
      pending_angles = {pending_angles, r};
   endfunction

   // Random gap length: mostly short, a few long.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result checker; stall is driven at the falling edge.
   initial begin
      int stall_left;
      rsp_type want;
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_angles.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_item);
               error_count++;
            end else begin
               want = pending_angles.pop_front();
               result_count++;
               if (want.degenerate) degenerate_count++;
               if (rsp_item !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_item);
                  error_count++;
               end
            end
         end
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_enable && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one matrix item and record its expected result. Valid stays high after
   // the item is taken so that items can follow back to back; an idle gap or
   // wait_drained lowers it.
   task automatic send_matrix(req_type m, bit allow_gap);
      int gap;
      gap = allow_gap ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= m;
      enqueue_expected(predict_angles(m));
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic req_type matrix_of(int v0, int v1, int v2, int v3, int v4,
                                          int v5, int v6, int v7, int v8);
      req_type m;
      m.xaxis_0 = 16'(v0); m.xaxis_1 = 16'(v1); m.xaxis_2 = 16'(v2);
      m.yaxis_0 = 16'(v3); m.yaxis_1 = 16'(v4); m.yaxis_2 = 16'(v5);
      m.zaxis_0 = 16'(v6); m.zaxis_1 = 16'(v7); m.zaxis_2 = 16'(v8);
      return m;
   endfunction

   // Proper rotation from random Euler-like angles, with small noise.
   function automatic req_type random_rotation();
      real a, b, c, ca, sa, cb, sb, cc, sc;
      real r [9];
      req_type m;
      a = ($urandom_range(0, 62831) / 10000.0);
      b = ($urandom_range(0, 62831) / 10000.0);
      c = ($urandom_range(0, 62831) / 10000.0);
      ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cc = $cos(c); sc = $sin(c);
      r = '{cb * cc, cb * sc, -sb,
            sa * sb * cc - ca * sc, sa * sb * sc + ca * cc, sa * cb,
            ca * sb * cc + sa * sc, ca * sb * sc - sa * cc, ca * cb};
      m = matrix_of(0, 0, 0, 0, 0, 0, 0, 0, 0);
      for (int k = 0; k < 9; k++)
         m[(8 - k) * 16 +: 16] = 16'($rtoi(r[k] * 16384.0) + $urandom_range(0, 4) - 2);
      return m;
   endfunction

   // Arbitrary element values, in range or using all sixteen bits.
   function automatic req_type random_noise();
      req_type m;
      for (int k = 0; k < 9; k++)
         m[k * 16 +: 16] = ($urandom_range(0, 1) == 0) ? 16'($urandom())
                                                        : 16'($urandom_range(0, 32768) - 16384);
      return m;
   endfunction

   // Stop sending, wait for every expected result, and return at a falling edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Directed cases: identity, each branch, extremes, degenerate and zero arguments.
   task automatic test_directed();
      send_matrix(matrix_of(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 0);
      send_matrix(matrix_of(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 0);
      send_matrix(matrix_of(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 0);
      send_matrix(matrix_of(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 0);
      send_matrix(matrix_of(0, 16384, 0, -16384, 0, 0, 0, 0, 16384), 0);
      send_matrix(matrix_of(0, 0, -16384, 0, 16384, 0, 16384, 0, 0), 0);
      send_matrix(matrix_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_matrix(matrix_of(-16384, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_matrix(matrix_of(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 0);
      send_matrix(matrix_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            32767), 0);
      send_matrix(matrix_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768), 0);
      send_matrix(matrix_of(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                            -1), 0);
      send_matrix(matrix_of(-32768, 0, 0, 0, 32767, 0, 0, 0, -32768), 0);
      send_matrix(matrix_of(0, 0, 16384, 0, 16384, 0, -16384, 0, 0), 0);
      send_matrix(matrix_of(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
                            16384), 0);
      send_matrix(matrix_of(16384, 0, 0, 0, 0, -16384, 0, 16384, 0), 0);
   endtask

   // Random traffic, mostly proper rotations.
   task automatic test_random(int count, bit with_gaps);
      for (int n = 0; n < count; n++)
         send_matrix(($urandom_range(0, 9) < 7) ? random_rotation() : random_noise(),
                     with_gaps);
   endtask

   // Test sequence.
   initial begin
      error_count = 0;
      result_count = 0;
      degenerate_count = 0;
      rsp_idle_enable = 1'b0;
      req_valid = 1'b0;
      req_item = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      rsp_idle_enable = 1'b1;
      test_random(600, 1);
      // Hold off until the pipeline has emptied.
      wait_drained();
      rsp_idle_enable = 1'b0;
      test_random(600, 0);
      rsp_idle_enable = 1'b1;
      test_random(600, 1);
      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);
      $display("Checked %0d results, %0d of them degenerate, across all four branches,",
               result_count, degenerate_count);
      $display("saturating inputs and random stalls on both channels.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d errors", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
